// ===== hdl/rlf_pkg.sv =====
// Package for the radial light falloff core: item types, config register
// codes, side-band struct and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package rlf_pkg;

  localparam int DIM_MAX     = 4096;
  localparam int SQRT_STEPS  = 29;
  localparam int DIV_STEPS   = 16;
  localparam int LOG_STEPS   = 16;
  localparam int EXP_TERMS   = 10;
  localparam int RECIP_SHIFT = 35;

  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    REG_CENTER_COL     = 3'd0,
    REG_CENTER_ROW     = 3'd1,
    REG_SPOT_RADIUS    = 3'd2,
    REG_FALLOFF_GAMMA  = 3'd3,
    REG_LIGHT_STRENGTH = 3'd4,
    REG_GAIN_CH0       = 3'd5,
    REG_GAIN_CH1       = 3'd6,
    REG_GAIN_CH2       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] center_col;
    logic [11:0] center_row;
    logic [12:0] spot_radius;
    logic [15:0] falloff_gamma;
    logic [15:0] light_strength;
    logic [15:0] gain_ch0;
    logic [15:0] gain_ch1;
    logic [15:0] gain_ch2;
  } cfg_t;

  typedef struct packed {
    logic [11:0] pix_row;
    logic [11:0] pix_col;
    logic [7:0]  in_ch0;
    logic [7:0]  in_ch1;
    logic [7:0]  in_ch2;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
  } res_item_t;

  typedef struct packed {
    logic       in_spot;
    logic       u_zero;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
  } side_t;

  function automatic logic [11:0] clamp_coord(input logic [11:0] v);
    return (13'(v) >= 13'(DIM_MAX)) ? 12'(DIM_MAX - 1) : v;
  endfunction

endpackage

// ===== hdl/rlf_dist.sv =====
// Distance front end: |dr|,|dc|, squares, spot test, bit-serial sqrt and
// radius division giving u in Q0.16. Depends on rlf_pkg.
`timescale 1ns / 1ps

module rlf_dist (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rlf_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  rlf_pkg::pix_item_t in_item,
  output logic              out_valid,
  output logic [15:0]       out_u,
  output rlf_pkg::side_t    out_side
);
  import rlf_pkg::*;

  logic [11:0] row_c, col_c, crow_c, ccol_c;
  logic [12:0] rad_c;

  logic        a_v;
  logic [11:0] a_dr, a_dc;
  side_t       a_side;

  logic        b_v;
  logic [23:0] b_sr, b_sc;
  side_t       b_side;

  logic [24:0] d_sum, rr;

  logic        sq_v    [0:SQRT_STEPS];
  logic [30:0] sq_rem  [0:SQRT_STEPS-1];
  logic [28:0] sq_root [0:SQRT_STEPS];
  logic [24:0] sq_d    [0:SQRT_STEPS-1];
  side_t       sq_side [0:SQRT_STEPS];

  logic        dv_v    [1:DIV_STEPS];
  logic [12:0] dv_rem  [1:DIV_STEPS-1];
  logic [15:0] dv_low  [1:DIV_STEPS-1];
  logic [15:0] dv_q    [1:DIV_STEPS];
  side_t       dv_side [1:DIV_STEPS];

  always_comb begin
    row_c  = clamp_coord(in_item.pix_row);
    col_c  = clamp_coord(in_item.pix_col);
    crow_c = clamp_coord(cfg.center_row);
    ccol_c = clamp_coord(cfg.center_col);
    rad_c  = (cfg.spot_radius > 13'(DIM_MAX)) ? 13'(DIM_MAX) : cfg.spot_radius;
    d_sum  = 25'(b_sr) + 25'(b_sc);
    rr     = 25'(rad_c) * 25'(rad_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v      <= 1'b0;
      b_v      <= 1'b0;
      sq_v[0]  <= 1'b0;
    end else if (en) begin
      a_v      <= in_valid;
      b_v      <= a_v;
      sq_v[0]  <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dr           <= (row_c >= crow_c) ? row_c - crow_c : crow_c - row_c;
      a_dc           <= (col_c >= ccol_c) ? col_c - ccol_c : ccol_c - col_c;
      a_side.in_spot <= 1'b0;
      a_side.u_zero  <= 1'b0;
      a_side.ch0     <= in_item.in_ch0;
      a_side.ch1     <= in_item.in_ch1;
      a_side.ch2     <= in_item.in_ch2;
      b_sr           <= 24'(a_dr) * 24'(a_dr);
      b_sc           <= 24'(a_dc) * 24'(a_dc);
      b_side         <= a_side;
      sq_d[0]        <= d_sum;
      sq_rem[0]      <= '0;
      sq_root[0]     <= '0;
      sq_side[0]     <= '{in_spot: (rad_c != 13'd0) && (d_sum < rr),
                          u_zero: b_side.u_zero,
                          ch0: b_side.ch0, ch1: b_side.ch1, ch2: b_side.ch2};
    end
  end

  // one result bit of floor(sqrt(d * 2^32)) per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int HI = 2 * SQRT_STEPS - 1 - 2 * j;
    logic [57:0] rad;
    logic [32:0] cur, trial;
    logic        ge;

    always_comb begin
      rad   = {1'b0, sq_d[j], 32'd0};
      cur   = {sq_rem[j], rad[HI -: 2]};
      trial = {2'b00, sq_root[j], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root[j+1] <= {sq_root[j][27:0], ge};
        sq_side[j+1] <= sq_side[j];
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          sq_rem[j+1] <= ge ? 31'(cur - trial) : cur[30:0];
          sq_d[j+1]   <= sq_d[j];
        end
      end
    end
  end

  // restoring division by the radius, one quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic        v_i;
    logic [12:0] rem_i;
    logic [15:0] low_i, q_i;
    side_t       side_i;
    logic [13:0] tmp;
    logic        ge;

    if (i == 0) begin : g_first
      always_comb begin
        v_i    = sq_v[SQRT_STEPS];
        rem_i  = sq_root[SQRT_STEPS][28:16];
        low_i  = sq_root[SQRT_STEPS][15:0];
        q_i    = '0;
        side_i = sq_side[SQRT_STEPS];
      end
    end else begin : g_next
      always_comb begin
        v_i    = dv_v[i];
        rem_i  = dv_rem[i];
        low_i  = dv_low[i];
        q_i    = dv_q[i];
        side_i = dv_side[i];
      end
    end

    always_comb begin
      tmp = {rem_i, low_i[15]};
      ge  = tmp >= {1'b0, rad_c};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[i+1]    <= {q_i[14:0], ge};
        dv_side[i+1] <= side_i;
      end
    end

    if (i < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[i+1] <= ge ? 13'(tmp - {1'b0, rad_c}) : tmp[12:0];
          dv_low[i+1] <= {low_i[14:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = dv_v[DIV_STEPS];
  assign out_u     = dv_q[DIV_STEPS];
  assign out_side  = dv_side[DIV_STEPS];

endmodule

// ===== hdl/rlf_log.sv =====
// -log2(u) by normalize and repeated squaring, then scaling by gamma.
// Depends on rlf_pkg.
`timescale 1ns / 1ps

module rlf_log (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [15:0]    falloff_gamma,
  input  logic           in_valid,
  input  logic [15:0]    in_u,
  input  rlf_pkg::side_t in_side,
  output logic           out_valid,
  output logic [24:0]    out_p,
  output rlf_pkg::side_t out_side
);
  import rlf_pkg::*;

  logic [3:0]  msb;
  logic [30:0] norm;

  logic        lg_v    [0:LOG_STEPS];
  logic [30:0] lg_m    [0:LOG_STEPS-1];
  logic [15:0] lg_frac [0:LOG_STEPS];
  logic [3:0]  lg_k    [0:LOG_STEPS];
  side_t       lg_side [0:LOG_STEPS];

  logic        t_v;
  logic [20:0] t_val;
  side_t       t_side;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (in_u[i]) begin
        msb = 4'(i);
      end
    end
    norm = 31'(in_u) << (5'd30 - {1'b0, msb});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_v[0]   <= 1'b0;
      t_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      lg_v[0]   <= in_valid;
      t_v       <= lg_v[LOG_STEPS];
      out_valid <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_m[0]    <= norm;
      lg_k[0]    <= msb;
      lg_frac[0] <= '0;
      lg_side[0] <= '{in_spot: in_side.in_spot, u_zero: (in_u == 16'd0),
                      ch0: in_side.ch0, ch1: in_side.ch1, ch2: in_side.ch2};
      t_val    <= {5'd16 - {1'b0, lg_k[LOG_STEPS]}, 16'd0} - {5'd0, lg_frac[LOG_STEPS]};
      t_side   <= lg_side[LOG_STEPS];
      out_p    <= 25'((37'(t_val) * 37'(falloff_gamma)) >> 12);
      out_side <= t_side;
    end
  end

  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_sq
    logic [61:0] sqr;
    logic [31:0] m2;

    always_comb begin
      sqr = 62'(lg_m[j]) * 62'(lg_m[j]);
      m2  = sqr[61:30];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lg_v[j+1] <= 1'b0;
      end else if (en) begin
        lg_v[j+1] <= lg_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lg_frac[j+1] <= {lg_frac[j][14:0], m2[31]};
        lg_k[j+1]    <= lg_k[j];
        lg_side[j+1] <= lg_side[j];
      end
    end

    if (j < LOG_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          lg_m[j+1] <= m2[31] ? m2[31:1] : m2[30:0];
        end
      end
    end
  end

endmodule

// ===== hdl/rlf_exp.sv =====
// 2^-p: series for the fraction (multiply, reciprocal divide, correct per
// term), then clamp and integer shift. Depends on rlf_pkg.
`timescale 1ns / 1ps

module rlf_exp (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [24:0]    in_p,
  input  rlf_pkg::side_t in_side,
  output logic           out_valid,
  output logic [16:0]    out_pw,
  output rlf_pkg::side_t out_side
);
  import rlf_pkg::*;

  logic [47:0] zprod;

  logic               tb_v    [0:EXP_TERMS];
  logic [32:0]        tb_term [0:EXP_TERMS-1];
  logic signed [35:0] tb_acc  [0:EXP_TERMS];
  logic [31:0]        tb_z    [0:EXP_TERMS-1];
  logic [8:0]         tb_ip   [0:EXP_TERMS];
  side_t              tb_side [0:EXP_TERMS];

  logic signed [35:0] acc_f;
  logic [32:0]        e_val;

  always_comb begin
    zprod = 48'(in_p[15:0]) * 48'(LN2_Q32);
    acc_f = tb_acc[EXP_TERMS];
    if (acc_f < 36'sd0) begin
      e_val = '0;
    end else if (acc_f > $signed({3'd0, ONE_Q32})) begin
      e_val = ONE_Q32;
    end else begin
      e_val = acc_f[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tb_v[0]   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      tb_v[0]   <= in_valid;
      out_valid <= tb_v[EXP_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tb_z[0]    <= zprod[47:16];
      tb_term[0] <= ONE_Q32;
      tb_acc[0]  <= $signed({3'd0, ONE_Q32});
      tb_ip[0]   <= in_p[24:16];
      tb_side[0] <= in_side;
      if (tb_ip[EXP_TERMS] >= 9'd32) begin
        out_pw <= '0;
      end else begin
        out_pw <= 17'(e_val >> (6'd16 + {1'b0, tb_ip[EXP_TERMS][4:0]}));
      end
      out_side <= tb_side[EXP_TERMS];
    end
  end

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int K = j + 1;

    logic [64:0]        prod;
    logic               ma_v;
    logic [31:0]        ma_x;
    logic signed [35:0] ma_acc;
    logic [31:0]        ma_z;
    logic [8:0]         ma_ip;
    side_t              ma_side;

    logic [31:0]        q_est;
    logic               mb_v;
    logic [31:0]        mb_x, mb_q;
    logic signed [35:0] mb_acc;
    logic [31:0]        mb_z;
    logic [8:0]         mb_ip;
    side_t              mb_side;

    logic [35:0]        rem;
    logic [31:0]        q;

    always_comb begin
      prod = 65'(tb_term[j]) * 65'(tb_z[j]);
    end

    if (K == 1) begin : g_unit
      always_comb begin
        q_est = ma_x;
      end
    end else begin : g_recip
      localparam logic [34:0] RECIP = 35'((64'd1 << RECIP_SHIFT) / K);
      logic [66:0] y;
      always_comb begin
        y     = 67'(ma_x) * 67'(RECIP);
        q_est = y[66:35];
      end
    end

    always_comb begin
      rem = 36'(mb_x) - 36'(mb_q) * 36'(K);
      q   = (rem >= 36'(K)) ? mb_q + 32'd1 : mb_q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ma_v      <= 1'b0;
        mb_v      <= 1'b0;
        tb_v[j+1] <= 1'b0;
      end else if (en) begin
        ma_v      <= tb_v[j];
        mb_v      <= ma_v;
        tb_v[j+1] <= mb_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ma_x    <= prod[63:32];
        ma_acc  <= tb_acc[j];
        ma_z    <= tb_z[j];
        ma_ip   <= tb_ip[j];
        ma_side <= tb_side[j];
        mb_x    <= ma_x;
        mb_q    <= q_est;
        mb_acc  <= ma_acc;
        mb_z    <= ma_z;
        mb_ip   <= ma_ip;
        mb_side <= ma_side;
        if (K % 2 == 1) begin
          tb_acc[j+1] <= mb_acc - $signed({4'd0, q});
        end else begin
          tb_acc[j+1] <= mb_acc + $signed({4'd0, q});
        end
        tb_ip[j+1]   <= mb_ip;
        tb_side[j+1] <= mb_side;
      end
    end

    if (j < EXP_TERMS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          tb_term[j+1] <= {1'b0, q};
          tb_z[j+1]    <= mb_z;
        end
      end
    end
  end

endmodule

// ===== hdl/rlf_mix.sv =====
// Falloff scaling by strength and per-channel gain, saturating add inside the
// spot (other pixels pass through) and the result register. Depends on rlf_pkg.
`timescale 1ns / 1ps

module rlf_mix (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  rlf_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  logic [16:0]        in_pw,
  input  rlf_pkg::side_t     in_side,
  output logic               out_valid,
  output rlf_pkg::res_item_t out_item
);
  import rlf_pkg::*;

  logic [16:0] pw_eff;
  logic        f_v;
  logic [32:0] f_fo;
  side_t       f_side;

  logic [48:0] p0, p1, p2;
  logic        g_v;
  logic [10:0] g_add0, g_add1, g_add2;
  side_t       g_side;

  logic [11:0] s0, s1, s2;

  always_comb begin
    if (in_side.u_zero) begin
      pw_eff = (cfg.falloff_gamma == 16'd0) ? ONE_Q16 : 17'd0;
    end else begin
      pw_eff = in_pw;
    end
    p0 = 49'(f_fo) * 49'(cfg.gain_ch0);
    p1 = 49'(f_fo) * 49'(cfg.gain_ch1);
    p2 = 49'(f_fo) * 49'(cfg.gain_ch2);
    s0 = 12'(g_side.ch0) + 12'(g_add0);
    s1 = 12'(g_side.ch1) + 12'(g_add1);
    s2 = 12'(g_side.ch2) + 12'(g_add2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v       <= 1'b0;
      g_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f_v       <= in_valid;
      g_v       <= f_v;
      out_valid <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_fo   <= 33'(cfg.light_strength) * 33'(ONE_Q16 - pw_eff);
      f_side <= in_side;
      g_add0 <= p0[48:38];
      g_add1 <= p1[48:38];
      g_add2 <= p2[48:38];
      g_side <= f_side;
      if (g_side.in_spot) begin
        out_item.out_ch0 <= (s0 > 12'd255) ? 8'd255 : s0[7:0];
        out_item.out_ch1 <= (s1 > 12'd255) ? 8'd255 : s1[7:0];
        out_item.out_ch2 <= (s2 > 12'd255) ? 8'd255 : s2[7:0];
      end else begin
        out_item.out_ch0 <= g_side.ch0;
        out_item.out_ch1 <= g_side.ch1;
        out_item.out_ch2 <= g_side.ch2;
      end
    end
  end

endmodule

// ===== hdl/radial_light_falloff_core.sv =====
// Top level of the radial light falloff core: config registers, pipeline
// enable and the four pipeline sections. Depends on rlf_pkg, rlf_dist,
// rlf_log, rlf_exp, rlf_mix.
//
//  channel | signals                              | moves
//  pix     | pix_valid, pix_stall, pix            | one pixel item in
//  res     | res_valid, res_stall, res            | one result item out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | one register write
//
// One item per cycle sustained while no stalled result holds the pipeline; the path runs
// through the 29-step square root, 16-step divider, 16 squaring stages and 30 series stages.
// rst is synchronous and clears all valid bits and loads register defaults.
// A stalled result freezes the whole pipeline; pix_stall follows at once.
`timescale 1ns / 1ps

module radial_light_falloff_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  rlf_pkg::pix_item_t  pix,
  output logic                res_valid,
  input  logic                res_stall,
  output rlf_pkg::res_item_t  res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rlf_pkg::cfg_reg_t   cfg_index,
  input  logic [15:0]         cfg_data
);
  import rlf_pkg::*;

  cfg_t        cfg;
  logic        en;

  logic        d_v;
  logic [15:0] d_u;
  side_t       d_side;
  logic        l_v;
  logic [24:0] l_p;
  side_t       l_side;
  logic        e_v;
  logic [16:0] e_pw;
  side_t       e_side;

  assign cfg_ready = 1'b1;
  assign en        = !(res_valid && res_stall);
  assign pix_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_col     <= 12'd0;
      cfg.center_row     <= 12'd0;
      cfg.spot_radius    <= 13'd1024;
      cfg.falloff_gamma  <= 16'd4096;
      cfg.light_strength <= 16'd25600;
      cfg.gain_ch0       <= 16'd16384;
      cfg.gain_ch1       <= 16'd16384;
      cfg.gain_ch2       <= 16'd16384;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_COL:     cfg.center_col     <= cfg_data[11:0];
        REG_CENTER_ROW:     cfg.center_row     <= cfg_data[11:0];
        REG_SPOT_RADIUS:    cfg.spot_radius    <= cfg_data[12:0];
        REG_FALLOFF_GAMMA:  cfg.falloff_gamma  <= cfg_data;
        REG_LIGHT_STRENGTH: cfg.light_strength <= cfg_data;
        REG_GAIN_CH0:       cfg.gain_ch0       <= cfg_data;
        REG_GAIN_CH1:       cfg.gain_ch1       <= cfg_data;
        REG_GAIN_CH2:       cfg.gain_ch2       <= cfg_data;
      endcase
    end
  end

  rlf_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (pix_valid),
    .in_item   (pix),
    .out_valid (d_v),
    .out_u     (d_u),
    .out_side  (d_side)
  );

  rlf_log u_log (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .falloff_gamma (cfg.falloff_gamma),
    .in_valid      (d_v),
    .in_u          (d_u),
    .in_side       (d_side),
    .out_valid     (l_v),
    .out_p         (l_p),
    .out_side      (l_side)
  );

  rlf_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (l_v),
    .in_p      (l_p),
    .in_side   (l_side),
    .out_valid (e_v),
    .out_pw    (e_pw),
    .out_side  (e_side)
  );

  rlf_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (e_v),
    .in_pw     (e_pw),
    .in_side   (e_side),
    .out_valid (res_valid),
    .out_item  (res)
  );

endmodule

// ===== hdl/rlf_checker.sv =====
// Port-level checks for radial_light_falloff_core, bound to the top level.
// Depends on rlf_pkg.
`timescale 1ns / 1ps

module rlf_checker (
  input logic               clk,
  input logic               rst,
  input logic               pix_stall,
  input logic               res_valid,
  input logic               res_stall,
  input rlf_pkg::res_item_t res,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  a_stall_follows: assert property (@(posedge clk) disable iff (rst)
    pix_stall == (res_valid && res_stall))
    else $error("pix_stall does not track a held result");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind radial_light_falloff_core rlf_checker u_rlf_checker (.*);
